>>> rtl/rmbv_pkg.sv
`default_nettype none

package rmbv_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE = 1 << FRAC_BITS;

  typedef struct packed {
    logic [8:0][31:0]  pr;
    logic [2:0][32:0]  cr;
    logic [33:0]       dot;
    logic [2:0][30:0]  sc;
    logic [2:0]        neg;
    logic              degen;
    logic [30:0]       mx;
    logic [15:0]       c;
    logic [28:0]       c2;
    logic [2:0][61:0]  sq;
    logic [63:0]       bx;
    logic [34:0]       brem;
    logic [31:0]       broot;
    logic [29:0]       sx;
    logic [17:0]       srem;
    logic [14:0]       sroot;
    logic [31:0]       len;
    logic [14:0]       s;
    logic [2:0][45:0]  drem;
    logic [2:0][14:0]  q;
    logic [16:0]       t;
    logic [2:0][15:0]  u;
    logic [5:0][31:0]  pq;
    logic [2:0][31:0]  us;
    logic [5:0][15:0]  pqr;
    logic [2:0][15:0]  sr;
    logic [5:0][32:0]  pqt;
    logic [8:0][15:0]  m;
  } item_t;

  function automatic logic signed [63:0] rnd_f(input logic signed [63:0] v);
    logic [63:0] mag;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[63] ? $signed(64'(0) - mag) : $signed(mag);
  endfunction

  function automatic logic [15:0] sat16(input logic signed [63:0] v);
    logic [15:0] r;
    if (v > 64'sd32767) begin
      r = 16'h7fff;
    end else if (v < -64'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rmbv_in_if.sv
`default_nettype none

interface rmbv_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] a_x;
  logic signed [15:0] a_y;
  logic signed [15:0] a_z;
  logic signed [15:0] b_x;
  logic signed [15:0] b_y;
  logic signed [15:0] b_z;

  modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

`default_nettype wire

>>> rtl/rmbv_out_if.sv
`default_nettype none

interface rmbv_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m00;
  logic signed [15:0] m01;
  logic signed [15:0] m02;
  logic signed [15:0] m10;
  logic signed [15:0] m11;
  logic signed [15:0] m12;
  logic signed [15:0] m20;
  logic signed [15:0] m21;
  logic signed [15:0] m22;
  logic               degenerate;

  modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, degenerate,
                 input ready);
  modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, degenerate,
               output ready);
endinterface

`default_nettype wire

>>> rtl/rotation_matrix_between_vectors_core.sv
`default_nettype none
// Throughput: one beat per cycle, unless the output stalls with every stage full;
//   the 32-stage bit-per-stage square root of the axis length and the 15-stage
//   restoring divider set the depth.
// Each stage moves on when it or a later stage is empty, so bubbles collapse.
// Reset: synchronous, clears the stage valid bits only.

module rotation_matrix_between_vectors_core (
  input  logic        clk,
  input  logic        rst,
  rmbv_in_if.sink     pair,
  rmbv_out_if.source  mat
);
  import rmbv_pkg::*;

  localparam int NST = 65;

  item_t            st [NST];
  item_t            nx [NST];
  logic [NST-1:0]   v;
  logic [NST-1:0]   adv;

  always_comb begin
    for (int i = 0; i < NST; i++) begin
      adv[i] = mat.ready | (|(~v & ({NST{1'b1}} << i)));
    end
  end

  assign pair.ready = adv[0];

  for (genvar g = 0; g < NST; g++) begin : g_st
    if (g == 0) begin : g_mul
      always_comb begin
        nx[g]       = '0;
        nx[g].pr[0] = 32'(pair.a_y * pair.b_z);
        nx[g].pr[1] = 32'(pair.a_z * pair.b_y);
        nx[g].pr[2] = 32'(pair.a_z * pair.b_x);
        nx[g].pr[3] = 32'(pair.a_x * pair.b_z);
        nx[g].pr[4] = 32'(pair.a_x * pair.b_y);
        nx[g].pr[5] = 32'(pair.a_y * pair.b_x);
        nx[g].pr[6] = 32'(pair.a_x * pair.b_x);
        nx[g].pr[7] = 32'(pair.a_y * pair.b_y);
        nx[g].pr[8] = 32'(pair.a_z * pair.b_z);
      end
    end else if (g == 1) begin : g_sum
      always_comb begin
        nx[g] = st[g-1];
        for (int k = 0; k < 3; k++) begin
          nx[g].cr[k] = 33'($signed(st[g-1].pr[2*k])) - 33'($signed(st[g-1].pr[2*k+1]));
        end
        nx[g].dot = 34'($signed(st[g-1].pr[6])) + 34'($signed(st[g-1].pr[7]))
                  + 34'($signed(st[g-1].pr[8]));
      end
    end else if (g == 2) begin : g_mag
      always_comb begin
        logic signed [63:0] cr_r;
        nx[g] = st[g-1];
        for (int k = 0; k < 3; k++) begin
          nx[g].neg[k] = st[g-1].cr[k][32];
          nx[g].sc[k]  = st[g-1].cr[k][32] ? 31'(33'(0) - st[g-1].cr[k])
                                           : st[g-1].cr[k][30:0];
        end
        nx[g].degen = (st[g-1].cr[0] == '0) && (st[g-1].cr[1] == '0)
                   && (st[g-1].cr[2] == '0);
        cr_r = rnd_f(64'($signed(st[g-1].dot)));
        if (cr_r > 64'(ONE)) begin
          cr_r = 64'(ONE);
        end else if (cr_r < -64'(ONE)) begin
          cr_r = -64'(ONE);
        end
        nx[g].c = cr_r[15:0];
      end
    end else if (g == 3) begin : g_max
      always_comb begin
        logic [30:0]        m01;
        logic signed [31:0] csq;
        nx[g] = st[g-1];
        m01 = (st[g-1].sc[0] > st[g-1].sc[1]) ? st[g-1].sc[0] : st[g-1].sc[1];
        nx[g].mx = (m01 > st[g-1].sc[2]) ? m01 : st[g-1].sc[2];
        csq = $signed(st[g-1].c) * $signed(st[g-1].c);
        nx[g].c2 = csq[28:0];
      end
    end else if (g >= 4 && g <= 8) begin : g_norm
      localparam int SH = 16 >> (g - 4);
      always_comb begin
        nx[g] = st[g-1];
        if (st[g-1].mx[30 -: SH] == '0) begin
          nx[g].mx = st[g-1].mx << SH;
          for (int k = 0; k < 3; k++) begin
            nx[g].sc[k] = st[g-1].sc[k] << SH;
          end
        end
      end
    end else if (g == 9) begin : g_sq
      always_comb begin
        nx[g] = st[g-1];
        for (int k = 0; k < 3; k++) begin
          nx[g].sq[k] = 62'(st[g-1].sc[k]) * 62'(st[g-1].sc[k]);
        end
      end
    end else if (g == 10) begin : g_len2
      always_comb begin
        nx[g]       = st[g-1];
        nx[g].bx    = 64'(st[g-1].sq[0]) + 64'(st[g-1].sq[1]) + 64'(st[g-1].sq[2]);
        nx[g].brem  = '0;
        nx[g].broot = '0;
        nx[g].sx    = (30'(1) << (2 * FRAC_BITS)) - 30'(st[g-1].c2);
        nx[g].srem  = '0;
        nx[g].sroot = '0;
      end
    end else if (g >= 11 && g <= 42) begin : g_sqrt
      always_comb begin
        logic [34:0] r2;
        logic [34:0] tr;
        logic [17:0] q2;
        logic [17:0] qt;
        nx[g] = st[g-1];
        r2 = {st[g-1].brem[32:0], st[g-1].bx[63:62]};
        tr = {1'b0, st[g-1].broot, 2'b01};
        if (r2 >= tr) begin
          nx[g].brem  = r2 - tr;
          nx[g].broot = {st[g-1].broot[30:0], 1'b1};
        end else begin
          nx[g].brem  = r2;
          nx[g].broot = {st[g-1].broot[30:0], 1'b0};
        end
        nx[g].bx = st[g-1].bx << 2;
        q2 = {st[g-1].srem[15:0], st[g-1].sx[29:28]};
        qt = {1'b0, st[g-1].sroot, 2'b01};
        if (g >= 28) begin
          if (q2 >= qt) begin
            nx[g].srem  = q2 - qt;
            nx[g].sroot = {st[g-1].sroot[13:0], 1'b1};
          end else begin
            nx[g].srem  = q2;
            nx[g].sroot = {st[g-1].sroot[13:0], 1'b0};
          end
          nx[g].sx = st[g-1].sx << 2;
        end
      end
    end else if (g == 43) begin : g_rnd
      always_comb begin
        nx[g]     = st[g-1];
        nx[g].len = st[g-1].broot + 32'(st[g-1].brem > 35'(st[g-1].broot));
        nx[g].s   = st[g-1].sroot + 15'(st[g-1].srem > 18'(st[g-1].sroot));
      end
    end else if (g == 44) begin : g_dinit
      always_comb begin
        nx[g] = st[g-1];
        for (int k = 0; k < 3; k++) begin
          nx[g].drem[k] = (46'(st[g-1].sc[k]) << FRAC_BITS) + 46'(st[g-1].len >> 1);
          nx[g].q[k]    = '0;
        end
        nx[g].t = 17'(ONE) - 17'($signed(st[g-1].c));
      end
    end else if (g >= 45 && g <= 59) begin : g_div
      localparam int J = 59 - g;
      always_comb begin
        logic [46:0] dv;
        nx[g] = st[g-1];
        dv = 47'(st[g-1].len) << J;
        for (int k = 0; k < 3; k++) begin
          if (47'(st[g-1].drem[k]) >= dv) begin
            nx[g].drem[k]  = st[g-1].drem[k] - dv[45:0];
            nx[g].q[k][J]  = 1'b1;
          end
        end
      end
    end else if (g == 60) begin : g_sign
      always_comb begin
        nx[g] = st[g-1];
        for (int k = 0; k < 3; k++) begin
          nx[g].u[k] = st[g-1].neg[k] ? 16'(0) - 16'(st[g-1].q[k]) : 16'(st[g-1].q[k]);
        end
      end
    end else if (g == 61) begin : g_pq
      always_comb begin
        nx[g] = st[g-1];
        nx[g].pq[0] = 32'($signed(st[g-1].u[0]) * $signed(st[g-1].u[0]));
        nx[g].pq[1] = 32'($signed(st[g-1].u[1]) * $signed(st[g-1].u[1]));
        nx[g].pq[2] = 32'($signed(st[g-1].u[2]) * $signed(st[g-1].u[2]));
        nx[g].pq[3] = 32'($signed(st[g-1].u[0]) * $signed(st[g-1].u[1]));
        nx[g].pq[4] = 32'($signed(st[g-1].u[0]) * $signed(st[g-1].u[2]));
        nx[g].pq[5] = 32'($signed(st[g-1].u[1]) * $signed(st[g-1].u[2]));
        for (int k = 0; k < 3; k++) begin
          nx[g].us[k] = 32'($signed(st[g-1].u[k]) * $signed({1'b0, st[g-1].s}));
        end
      end
    end else if (g == 62) begin : g_pqr
      always_comb begin
        logic signed [63:0] r;
        nx[g] = st[g-1];
        for (int k = 0; k < 6; k++) begin
          r = rnd_f(64'($signed(st[g-1].pq[k])));
          nx[g].pqr[k] = r[15:0];
        end
        for (int k = 0; k < 3; k++) begin
          r = rnd_f(64'($signed(st[g-1].us[k])));
          nx[g].sr[k] = r[15:0];
        end
      end
    end else if (g == 63) begin : g_pqt
      always_comb begin
        nx[g] = st[g-1];
        for (int k = 0; k < 6; k++) begin
          nx[g].pqt[k] = 33'($signed(st[g-1].pqr[k]) * $signed(st[g-1].t));
        end
      end
    end else begin : g_mat
      always_comb begin
        logic signed [63:0] tt [6];
        logic signed [63:0] cc;
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        logic signed [63:0] zs;
        nx[g] = st[g-1];
        for (int k = 0; k < 6; k++) begin
          tt[k] = rnd_f(64'($signed(st[g-1].pqt[k])));
        end
        cc = 64'($signed(st[g-1].c));
        xs = 64'($signed(st[g-1].sr[0]));
        ys = 64'($signed(st[g-1].sr[1]));
        zs = 64'($signed(st[g-1].sr[2]));
        if (st[g-1].degen) begin
          for (int k = 0; k < 9; k++) begin
            nx[g].m[k] = (k % 4 == 0) ? sat16(64'(ONE)) : 16'(0);
          end
        end else begin
          nx[g].m[0] = sat16(cc + tt[0]);
          nx[g].m[1] = sat16(tt[3] - zs);
          nx[g].m[2] = sat16(tt[4] + ys);
          nx[g].m[3] = sat16(tt[3] + zs);
          nx[g].m[4] = sat16(cc + tt[1]);
          nx[g].m[5] = sat16(tt[5] - xs);
          nx[g].m[6] = sat16(tt[4] - ys);
          nx[g].m[7] = sat16(tt[5] + xs);
          nx[g].m[8] = sat16(cc + tt[2]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (adv[i]) begin
          v[i] <= (i == 0) ? pair.valid : v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) begin
      if (adv[i]) begin
        st[i] <= nx[i];
      end
    end
  end

  assign mat.valid      = v[NST-1];
  assign mat.m00        = st[NST-1].m[0];
  assign mat.m01        = st[NST-1].m[1];
  assign mat.m02        = st[NST-1].m[2];
  assign mat.m10        = st[NST-1].m[3];
  assign mat.m11        = st[NST-1].m[4];
  assign mat.m12        = st[NST-1].m[5];
  assign mat.m20        = st[NST-1].m[6];
  assign mat.m21        = st[NST-1].m[7];
  assign mat.m22        = st[NST-1].m[8];
  assign mat.degenerate = st[NST-1].degen;

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    v[2] |-> ($signed(st[2].c) <= ONE) && ($signed(st[2].c) >= -ONE))
    else $error("cosine out of range");

  a_norm: assert property (@(posedge clk) disable iff (rst)
    v[8] && !st[8].degen |-> st[8].mx[30])
    else $error("axis not normalized");

  a_len: assert property (@(posedge clk) disable iff (rst)
    v[43] && !st[43].degen |-> (st[43].len[31:30] != 2'b00))
    else $error("axis length too small");

  a_quot: assert property (@(posedge clk) disable iff (rst)
    v[59] && !st[59].degen |-> (st[59].q[0] <= 15'(ONE)) && (st[59].q[1] <= 15'(ONE))
                             && (st[59].q[2] <= 15'(ONE)))
    else $error("unit axis component above one");

  a_ident: assert property (@(posedge clk) disable iff (rst)
    mat.valid && mat.degenerate |-> (mat.m01 == 16'sd0) && (mat.m10 == 16'sd0)
                                  && (mat.m00 == mat.m22))
    else $error("degenerate beat not identity");

endmodule

`default_nettype wire
